>>> src/slewrq_pkg.sv
// Shared types and constants for the slew-target requantizer.
// Holds item payloads, configuration register codes and the controller/datapath link.
package slewrq_pkg;

    localparam int SampleW  = 32;
    localparam int ScaleW   = 48;
    localparam int SonW     = 17;
    localparam int InvW     = 22;
    localparam int DepthW   = 7;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 48;

    localparam logic [ScaleW-1:0] ScaleRst = 48'd549755813888;
    localparam logic [SonW-1:0]   SonRst   = 17'd53019;
    localparam logic [InvW-1:0]   InvRst   = 22'd512;
    localparam logic [DepthW-1:0] DepthRst = 7'd17;

    localparam logic [DepthW-1:0] DepthMin = 7'd3;
    localparam int                DepthCap = 98;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCALE     = 2'd0,
        CFG_SONORITY  = 2'd1,
        CFG_INV_SCALE = 2'd2,
        CFG_DEPTH     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SampleW-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SampleW-1:0] sample_out;
        logic signed [SampleW-1:0] level_out;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic lvl;
        logic gap;
        logic pick;
        logic scale;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> src/slewrq_if.sv
// Valid/ready channel carrying one item of payload type T.
// No dependencies.
interface slewrq_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/slewrq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module slewrq_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/slewrq_ctrl.sv
// Sequencing state machine: steps one item through the datapath.
// Depends on slewrq_pkg for the command and status types.
module slewrq_ctrl import slewrq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_LVL   = 8'b0000_1000,
        S_DIST  = 8'b0001_0000,
        S_PICK  = 8'b0010_0000,
        S_SCALE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_LVL;
            S_LVL:   n_state = S_DIST;
            S_DIST:  n_state = S_PICK;
            S_PICK:  n_state = S_SCALE;
            S_SCALE: n_state = S_OUT;
            S_OUT:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.sum   = (r_state == S_SUM);
        o_cmd.lvl   = (r_state == S_LVL);
        o_cmd.gap   = (r_state == S_DIST);
        o_cmd.pick  = (r_state == S_PICK);
        o_cmd.scale = (r_state == S_SCALE);
        o_cmd.out   = (r_state == S_OUT) && i_sts.out_free;
    end
endmodule

>>> src/slewrq_dp.sv
// Arithmetic, level history and output register of the requantizer.
// Depends on slewrq_pkg and slewrq_ram.
module slewrq_dp import slewrq_pkg::*; #(
    parameter int HISTORY_LEN = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic signed [SampleW-1:0] i_sample,
    input  logic [ScaleW-1:0]         i_scale,
    input  logic [SonW-1:0]           i_son,
    input  logic [InvW-1:0]           i_inv,
    input  logic [DepthW-1:0]         i_depth,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_item                 o_out_item
);
    localparam int AW   = $clog2(HISTORY_LEN);
    localparam int BW   = AW + 1;
    localparam int DMax = (DepthCap < HISTORY_LEN - 1) ? DepthCap : HISTORY_LEN - 1;
    localparam logic [DepthW-1:0] DepthMax = DepthW'(DMax);
    localparam logic [BW-1:0]     HistLen  = BW'(HISTORY_LEN);
    localparam logic [AW-1:0]     LastIdx  = AW'(HISTORY_LEN - 1);

    function automatic logic signed [31:0] sat_lvl(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat_prod(input logic signed [54:0] v);
        logic signed [31:0] res;
        if (v > 55'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -55'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [56:0] slew_dist(input logic signed [31:0] past,
                                              input logic signed [31:0] cand,
                                              input logic [24:0]        clamp);
        logic signed [32:0] slew;
        logic [32:0]        mag;
        logic [56:0]        a;
        logic [56:0]        c;
        slew = 33'(past) - 33'(cand);
        mag  = slew[32] ? 33'(-slew) : 33'(slew);
        a    = {mag, 24'd0};
        c    = 57'(clamp);
        return (a >= c) ? (a - c) : (c - a);
    endfunction

    logic                      r_neg;
    logic [31:0]               r_mag;
    logic [55:0]               r_p;
    logic [55:0]               r_q;
    logic [55:0]               r_t;
    logic                      r_fracnz;
    logic signed [31:0]        r_past;
    logic signed [31:0]        r_qa;
    logic signed [31:0]        r_qb;
    logic [24:0]               r_clamp;
    logic [56:0]               r_da;
    logic [56:0]               r_db;
    logic signed [31:0]        r_chosen;
    logic signed [54:0]        r_prod;
    logic [AW-1:0]             r_wp;
    logic [HISTORY_LEN-1:0]    r_vld;
    logic                      r_rd_vld;
    logic                      r_out_vld;
    t_out_item                 r_out;

    logic [DepthW-1:0]         depth_sat;
    logic [BW-1:0]             back;
    logic [BW-1:0]             wp_ext;
    logic [AW-1:0]             rd_idx;
    logic [31:0]               rd_data;
    logic [31:0]               mag_in;
    logic [55:0]               t_sum;
    logic [31:0]               ip;
    logic signed [33:0]        lo;
    logic [24:0]               son24;
    logic signed [31:0]        n_chosen;
    logic signed [54:0]        prod;

    always_comb begin
        if (i_depth < DepthMin) begin
            depth_sat = DepthMin;
        end else if (i_depth > DepthMax) begin
            depth_sat = DepthMax;
        end else begin
            depth_sat = i_depth;
        end
        back   = BW'(depth_sat) + BW'(1);
        wp_ext = BW'(r_wp);
        if (wp_ext >= back) begin
            rd_idx = AW'(wp_ext - back);
        end else begin
            rd_idx = AW'(wp_ext + (HistLen - back));
        end
    end

    slewrq_ram #(
        .W     (32),
        .DEPTH (HISTORY_LEN)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pick),
        .i_waddr (r_wp),
        .i_wdata (n_chosen),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    assign mag_in   = i_sample[31] ? (~i_sample + 32'd1) : i_sample;
    assign t_sum    = r_p + 56'(r_q[55:24]);
    assign ip       = r_t[55:24];
    assign lo       = r_neg ? (-$signed({2'b00, ip}) - $signed({33'd0, r_fracnz}))
                            : $signed({2'b00, ip});
    assign son24    = {i_son, 8'd0};
    assign n_chosen = (r_da < r_db) ? r_qa : r_qb;
    assign prod     = r_chosen * $signed({1'b0, i_inv});

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[rd_idx];
        if (i_cmd.load) begin
            r_neg <= i_sample[31];
            r_mag <= mag_in;
        end
        if (i_cmd.mul) begin
            r_p    <= r_mag * i_scale[47:24];
            r_q    <= r_mag * i_scale[23:0];
            r_past <= r_rd_vld ? $signed(rd_data) : 32'sd0;
        end
        if (i_cmd.sum) begin
            r_t      <= t_sum;
            r_fracnz <= (|t_sum[23:0]) || (|r_q[23:0]);
        end
        if (i_cmd.lvl) begin
            r_qa    <= sat_lvl(lo);
            r_qb    <= sat_lvl(lo + 34'sd1);
            r_clamp <= (r_t < 56'(son24)) ? r_t[24:0] : son24;
        end
        if (i_cmd.gap) begin
            r_da <= slew_dist(r_past, r_qa, r_clamp);
            r_db <= slew_dist(r_past, r_qb, r_clamp);
        end
        if (i_cmd.pick) begin
            r_chosen <= n_chosen;
        end
        if (i_cmd.scale) begin
            r_prod <= prod;
        end
        if (i_cmd.out) begin
            r_out.sample_out <= sat_prod(r_prod);
            r_out.level_out  <= r_chosen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.pick) begin
                r_vld[r_wp] <= 1'b1;
                r_wp        <= (r_wp == LastIdx) ? '0 : r_wp + AW'(1);
            end
            if (i_cmd.out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_item     = r_out;
endmodule

>>> src/slew_target_requantizer_core.sv
// Top level of the slew-target requantizer: configuration registers and wiring.
// Depends on slewrq_pkg, slewrq_if, slewrq_ctrl and slewrq_dp.

// Each accepted sample is scaled by scale_factor, split into the floor level and the
// level above it, and the level whose slew against the level history_depth+1 items back
// lies closest to min(|scaled sample|, sonority) is kept (ties keep the upper level).
// One item at a time: the result is loaded into the output register at the end of the
// controller's step sequence (multiply, add, level/clamp, slew distance, pick with
// history write, output scaling, output load), which waits while the output register
// still holds an untaken item; only then does the input take a new item. The history
// reads as zero after reset with no clearing pass; registers must be written only while
// the block is idle, which the block itself does not enforce.
module slew_target_requantizer_core import slewrq_pkg::*; #(
    parameter int HISTORY_LEN = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    slewrq_if.sink              i_sample,
    slewrq_if.source            o_result
);
    logic [ScaleW-1:0] r_scale;
    logic [SonW-1:0]   r_son;
    logic [InvW-1:0]   r_inv;
    logic [DepthW-1:0] r_depth;

    t_cmd      s_cmd;
    t_sts      s_sts;
    t_in_item  s_in;
    t_out_item s_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ScaleRst;
            r_son   <= SonRst;
            r_inv   <= InvRst;
            r_depth <= DepthRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE:     r_scale <= i_cfg_data[ScaleW-1:0];
                CFG_SONORITY:  r_son   <= i_cfg_data[SonW-1:0];
                CFG_INV_SCALE: r_inv   <= i_cfg_data[InvW-1:0];
                CFG_DEPTH:     r_depth <= i_cfg_data[DepthW-1:0];
                default:       r_depth <= r_depth;
            endcase
        end
    end

    assign s_in = i_sample.data;

    slewrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    slewrq_dp #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_sample    (s_in.sample_in),
        .i_scale     (r_scale),
        .i_son       (r_son),
        .i_inv       (r_inv),
        .i_depth     (r_depth),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_out_item  (s_out)
    );

    assign o_result.data = s_out;

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(s_cmd))
        else $error("more than one datapath command in a cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.valid && i_sample.ready |=> !i_sample.ready)
        else $error("item accepted while previous item in flight");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out |-> (!o_result.valid || o_result.ready))
        else $error("output register overwritten before its item was taken");

    a_pick_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.pick |-> $past(s_cmd.gap))
        else $error("level picked without distance step");
`endif
endmodule
